[design/vna_pkg.sv]
`timescale 1ns / 1ps
package vna_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TRI  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// index source for store access
	typedef enum logic [1:0] {
		SEL_A  = 2'd0,
		SEL_B  = 2'd1,
		SEL_C  = 2'd2,
		SEL_VI = 2'd3
	} sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_LOAD, ST_RD_ISS, ST_RD_TAKE,
		ST_RA, ST_RB, ST_RC, ST_TC, ST_EDGE, ST_HALVE, ST_MUL, ST_MAG,
		ST_NORM, ST_SQ, ST_SQI, ST_SQRT, ST_DIVI, ST_DIV, ST_DIVW,
		ST_UPD_RD, ST_UPD_WR, ST_DONE
	} state_t;

	localparam int CNT_W = 6;

	typedef struct packed {
		logic             cap;
		logic             load_wr;
		logic             rd;
		sel_t             rd_sel;
		logic             take;
		sel_t             take_sel;
		logic             res_take;
		logic             edge_calc;
		logic             halve;
		logic             mul;
		logic             mag;
		logic             shr;
		logic             shl;
		logic             sq;
		logic             sq_init;
		logic             sqrt;
		logic             div_init;
		logic             div_step;
		logic             div_wr;
		logic [1:0]       comp;
		logic             upd_wr;
		logic             out_ld;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic oor;
		logic cr_zero;
		logic norm_hi;
		logic norm_lo;
		logic out_free;
	} sts_t;

endpackage

[design/vna_if.sv]
`timescale 1ns / 1ps
interface vna_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] vertex_index;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] init_nx;
	logic signed [31:0] init_ny;
	logic signed [31:0] init_nz;
	logic [15:0] corner_a;
	logic [15:0] corner_b;
	logic [15:0] corner_c;

	modport source (output valid, op, vertex_index, pos_x, pos_y, pos_z,
		init_nx, init_ny, init_nz, corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, op, vertex_index, pos_x, pos_y, pos_z,
		init_nx, init_ny, init_nz, corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic signed [31:0] out_nx;
	logic signed [31:0] out_ny;
	logic signed [31:0] out_nz;

	modport source (output valid, status, out_nx, out_ny, out_nz, input ready);
	modport sink (input valid, status, out_nx, out_ny, out_nz, output ready);
endinterface

[design/vna_ram.sv]
`timescale 1ns / 1ps
module vna_ram #(
	parameter int W     = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/vna_ctrl.sv]
`timescale 1ns / 1ps
module vna_ctrl import vna_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       comp_q;
	logic [1:0]       corner_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_DISP;
			ST_DISP: begin
				if (sts.oor) begin
					state_d = ST_DONE;
				end else begin
					unique case (sts.op)
						OP_LOAD: state_d = ST_LOAD;
						OP_READ: state_d = ST_RD_ISS;
						OP_TRI:  state_d = ST_RA;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD:    state_d = ST_DONE;
			ST_RD_ISS:  state_d = ST_RD_TAKE;
			ST_RD_TAKE: state_d = ST_DONE;
			ST_RA:      state_d = ST_RB;
			ST_RB:      state_d = ST_RC;
			ST_RC:      state_d = ST_TC;
			ST_TC:      state_d = ST_EDGE;
			ST_EDGE:    state_d = ST_HALVE;
			ST_HALVE:   state_d = ST_MUL;
			ST_MUL:     if (cnt_q == 6'd6) state_d = ST_MAG;
			ST_MAG:     state_d = ST_NORM;
			ST_NORM: begin
				if (sts.cr_zero) begin
					state_d = ST_UPD_RD;
				end else if (!sts.norm_hi && !sts.norm_lo) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ:      if (cnt_q == 6'd3) state_d = ST_SQI;
			ST_SQI:     state_d = ST_SQRT;
			ST_SQRT:    if (cnt_q == 6'd31) state_d = ST_DIVI;
			ST_DIVI:    state_d = ST_DIV;
			ST_DIV:     if (cnt_q == 6'd16) state_d = ST_DIVW;
			ST_DIVW:    state_d = (comp_q == 2'd2) ? ST_UPD_RD : ST_DIVI;
			ST_UPD_RD:  state_d = ST_UPD_WR;
			ST_UPD_WR:  state_d = (corner_q == 2'd2) ? ST_DONE : ST_UPD_RD;
			ST_DONE:    if (sts.out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.cnt = cnt_q;
		cmd.comp = comp_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			ST_LOAD:    cmd.load_wr = 1'b1;
			ST_RD_ISS: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = SEL_VI;
			end
			ST_RD_TAKE: cmd.res_take = 1'b1;
			ST_RA: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = SEL_A;
			end
			ST_RB: begin
				cmd.rd       = 1'b1;
				cmd.rd_sel   = SEL_B;
				cmd.take     = 1'b1;
				cmd.take_sel = SEL_A;
			end
			ST_RC: begin
				cmd.rd       = 1'b1;
				cmd.rd_sel   = SEL_C;
				cmd.take     = 1'b1;
				cmd.take_sel = SEL_B;
			end
			ST_TC: begin
				cmd.take     = 1'b1;
				cmd.take_sel = SEL_C;
			end
			ST_EDGE:    cmd.edge_calc = 1'b1;
			ST_HALVE:   cmd.halve = 1'b1;
			ST_MUL:     cmd.mul = 1'b1;
			ST_MAG:     cmd.mag = 1'b1;
			ST_NORM: begin
				cmd.shr = !sts.cr_zero && sts.norm_hi;
				cmd.shl = !sts.cr_zero && !sts.norm_hi && sts.norm_lo;
			end
			ST_SQ:      cmd.sq = 1'b1;
			ST_SQI:     cmd.sq_init = 1'b1;
			ST_SQRT:    cmd.sqrt = 1'b1;
			ST_DIVI:    cmd.div_init = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_DIVW:    cmd.div_wr = 1'b1;
			ST_UPD_RD: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = sel_t'(corner_q);
			end
			ST_UPD_WR: begin
				cmd.upd_wr   = 1'b1;
				cmd.take_sel = sel_t'(corner_q);
			end
			ST_DONE:    cmd.out_ld = sts.out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			comp_q   <= '0;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 6'd1;
			if (state_q == ST_MAG) begin
				comp_q <= '0;
			end else if (state_q == ST_DIVW) begin
				comp_q <= comp_q + 2'd1;
			end
			if (state_q == ST_EDGE) begin
				corner_q <= '0;
			end else if (state_q == ST_UPD_WR) begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end

	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (cnt_q <= 6'd31))
		else $error("square root ran past its step count");
	a_done_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && sts.out_free) |=> (state_q == ST_IDLE))
		else $error("finished word not released");
	a_div_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVI) |-> (comp_q <= 2'd2))
		else $error("division component out of range");
endmodule

[design/vna_dp.sv]
`timescale 1ns / 1ps
module vna_dp import vna_pkg::*; #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  op,
	input  logic [15:0] vertex_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] init_nx,
	input  logic signed [31:0] init_ny,
	input  logic signed [31:0] init_nz,
	input  logic [15:0] corner_a,
	input  logic [15:0] corner_b,
	input  logic [15:0] corner_c,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        status,
	output logic signed [31:0] out_nx,
	output logic signed [31:0] out_ny,
	output logic signed [31:0] out_nz
);
	localparam int AW = $clog2(VERTEX_SLOTS);
	localparam logic [16:0] SLOTS = 17'(VERTEX_SLOTS);

	function automatic logic is_big(input logic signed [32:0] v);
		return (v[32:31] != 2'b00) && !((v[32:31] == 2'b11) && (|v[30:0]));
	endfunction

	// halve magnitude, truncating toward zero
	function automatic logic signed [32:0] half_tz(input logic signed [32:0] v);
		logic signed [32:0] neg_v;
		neg_v = -v;
		return v[32] ? -(neg_v >>> 1) : (v >>> 1);
	endfunction

	op_t         op_q;
	logic [15:0] vi_q, ca_q, cb_q, cc_q;
	logic        oor_q;
	logic [95:0] pos_in_q, nrm_in_q;

	logic [AW-1:0] raddr, nwaddr;
	logic          nwe;
	logic [95:0]   pos_rdata, nrm_rdata, nwdata;

	logic signed [31:0] pt_q [3][3];
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_full;
	logic signed [63:0] prod_q, tmp_q;
	logic signed [63:0] cr_q [3];
	logic [63:0] m_q [3];
	logic        neg_q [3];
	logic [63:0] sum_q, v_q, res_q, bit_q, sq_t;
	logic [31:0] rem_q;
	logic [16:0] dq_q, q_q;
	logic [32:0] r2;
	logic signed [17:0] n_q [3];
	logic signed [31:0] res_n_q [3];
	logic signed [31:0] sat_n [3];
	logic        big;
	logic [2:0]  term;
	logic        out_valid_q, out_status_q;
	logic signed [31:0] out_n_q [3];

	vna_ram #(.W(96), .DEPTH(VERTEX_SLOTS)) u_pos_ram (
		.clk(clk), .we(cmd.load_wr), .waddr(vi_q[AW-1:0]), .wdata(pos_in_q),
		.raddr(raddr), .rdata(pos_rdata));

	vna_ram #(.W(96), .DEPTH(VERTEX_SLOTS)) u_nrm_ram (
		.clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
		.raddr(raddr), .rdata(nrm_rdata));

	always_comb begin
		unique case (cmd.rd_sel)
			SEL_A:   raddr = ca_q[AW-1:0];
			SEL_B:   raddr = cb_q[AW-1:0];
			SEL_C:   raddr = cc_q[AW-1:0];
			default: raddr = vi_q[AW-1:0];
		endcase
	end

	// saturating add of the unit normal onto the stored normal
	always_comb begin
		logic signed [32:0] s;
		for (int k = 0; k < 3; k++) begin
			s = 33'(signed'(nrm_rdata[32*k +: 32])) + 33'(n_q[k]);
			if (s > 33'sh0_7FFF_FFFF) begin
				sat_n[k] = 32'sh7FFF_FFFF;
			end else if (s < -33'sh0_8000_0000) begin
				sat_n[k] = 32'sh8000_0000;
			end else begin
				sat_n[k] = s[31:0];
			end
		end
	end

	always_comb begin
		nwe = cmd.load_wr || cmd.upd_wr;
		if (cmd.load_wr) begin
			nwaddr = vi_q[AW-1:0];
			nwdata = nrm_in_q;
		end else begin
			unique case (cmd.take_sel)
				SEL_A:   nwaddr = ca_q[AW-1:0];
				SEL_B:   nwaddr = cb_q[AW-1:0];
				SEL_C:   nwaddr = cc_q[AW-1:0];
				default: nwaddr = vi_q[AW-1:0];
			endcase
			nwdata = {sat_n[2], sat_n[1], sat_n[0]};
		end
	end

	always_comb begin
		big = 1'b0;
		for (int k = 0; k < 3; k++) begin
			big = big | is_big(e1_q[k]) | is_big(e2_q[k]);
		end
	end

	// one shared 33x33 multiplier: cross terms, then squares
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul) begin
			unique case (cmd.cnt[2:0])
				3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
				3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
				3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
				3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
				3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
				3'd5: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			unique case (cmd.cnt[1:0])
				2'd0: mul_a = {2'b00, m_q[0][30:0]};
				2'd1: mul_a = {2'b00, m_q[1][30:0]};
				2'd2: mul_a = {2'b00, m_q[2][30:0]};
				default: mul_a = '0;
			endcase
			mul_b = mul_a;
		end
	end

	assign prod_full = mul_a * mul_b;
	assign term      = cmd.cnt[2:0] - 3'd1;
	assign sq_t      = res_q + bit_q;
	assign r2        = {rem_q, dq_q[16]};

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q     <= op_t'(op);
			vi_q     <= vertex_index;
			ca_q     <= corner_a;
			cb_q     <= corner_b;
			cc_q     <= corner_c;
			pos_in_q <= {pos_z, pos_y, pos_x};
			nrm_in_q <= {init_nz, init_ny, init_nx};
			unique case (op_t'(op))
				OP_LOAD, OP_READ: oor_q <= {1'b0, vertex_index} >= SLOTS;
				OP_TRI: oor_q <= ({1'b0, corner_a} >= SLOTS) ||
					({1'b0, corner_b} >= SLOTS) || ({1'b0, corner_c} >= SLOTS);
				default: oor_q <= 1'b0;
			endcase
			for (int k = 0; k < 3; k++) begin
				res_n_q[k] <= '0;
			end
		end
		if (cmd.res_take) begin
			for (int k = 0; k < 3; k++) begin
				res_n_q[k] <= nrm_rdata[32*k +: 32];
			end
		end
		if (cmd.take) begin
			for (int k = 0; k < 3; k++) begin
				pt_q[cmd.take_sel][k] <= pos_rdata[32*k +: 32];
			end
		end
		if (cmd.edge_calc) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= 33'(pt_q[1][k]) - 33'(pt_q[0][k]);
				e2_q[k] <= 33'(pt_q[2][k]) - 33'(pt_q[0][k]);
				n_q[k]  <= '0;
			end
		end
		if (cmd.halve && big) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= half_tz(e1_q[k]);
				e2_q[k] <= half_tz(e2_q[k]);
			end
		end
		if (cmd.mul || cmd.sq) begin
			prod_q <= prod_full[63:0];
		end
		if (cmd.mul && cmd.cnt != '0) begin
			if (!term[0]) begin
				tmp_q <= prod_q;
			end else begin
				cr_q[term[2:1]] <= tmp_q - prod_q;
			end
		end
		if (cmd.mag) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= cr_q[k][63];
				m_q[k]   <= cr_q[k][63] ? 64'(-cr_q[k]) : 64'(cr_q[k]);
			end
		end
		if (cmd.shr) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k] <= m_q[k] >> 1;
			end
		end
		if (cmd.shl) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k] <= m_q[k] << 1;
			end
		end
		if (cmd.sq && cmd.cnt != '0) begin
			sum_q <= (cmd.cnt == 6'd1) ? prod_q[63:0] : sum_q + prod_q[63:0];
		end
		if (cmd.sq_init) begin
			v_q   <= sum_q;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end
		if (cmd.sqrt) begin
			if (v_q >= sq_t) begin
				v_q   <= v_q - sq_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		// quotient < 2^17, so the top dividend bits already sit below len
		if (cmd.div_init) begin
			rem_q <= {2'b00, m_q[cmd.comp][30:1]};
			dq_q  <= {m_q[cmd.comp][0], 16'h0000};
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			if (r2 >= {1'b0, res_q[31:0]}) begin
				rem_q <= 32'(r2 - {1'b0, res_q[31:0]});
				q_q   <= {q_q[15:0], 1'b1};
			end else begin
				rem_q <= r2[31:0];
				q_q   <= {q_q[15:0], 1'b0};
			end
			dq_q <= dq_q << 1;
		end
		if (cmd.div_wr) begin
			n_q[cmd.comp] <= neg_q[cmd.comp] ? -{1'b0, q_q} : {1'b0, q_q};
		end
		if (cmd.out_ld) begin
			out_status_q <= oor_q;
			for (int k = 0; k < 3; k++) begin
				out_n_q[k] <= res_n_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.op       = op_q;
		sts.oor      = oor_q;
		sts.cr_zero  = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
		sts.norm_hi  = (|m_q[0][63:31]) || (|m_q[1][63:31]) || (|m_q[2][63:31]);
		sts.norm_lo  = !(|m_q[0][63:30]) && !(|m_q[1][63:30]) && !(|m_q[2][63:30]);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_nx    = out_n_q[0];
	assign out_ny    = out_n_q[1];
	assign out_nz    = out_n_q[2];

	a_len_norm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (|res_q[31:30]))
		else $error("vector length below normalized range");
	a_unit_q: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_wr |-> (q_q <= 17'd65536))
		else $error("unit component above one");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result word dropped while stalled");
endmodule

[design/vertex_normal_accumulator.sv]
`timescale 1ns / 1ps
// Vertex normal accumulator.
// req (sink): one word per op. op 0 loads position and starting normal of
//   vertex_index, op 1 adds the unit face normal of triangle corner_a/b/c to
//   the three corners' normals (saturating), op 2 reads a vertex normal.
// rsp (source): one word per request: status (1 = index out of range, store
//   untouched) and out_nx/ny/nz (read result, zero otherwise).
// A triangle runs the cross product on the shared 33x33 multiplier, one-bit
//   normalizing shifts, the squares, 32 square root steps, three restoring
//   divisions and the read-modify-write of the three corners through the
//   normal store port; a zero cross product skips from normalization to
//   the read-modify-write.
// One request is in flight at a time; req.ready is high only when idle.
// The result sits in an output register; if rsp stalls, the finished word
//   waits there and the next request is still taken, but its result waits
//   until the register drains.
// Reset clears the control state only; the vertex stores are undefined until
//   loaded, and reading a never-loaded slot returns garbage.
module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int VERTEX_SLOTS = 1024
) (
	input logic      clk,
	input logic      arst_n,
	vna_in_if.sink   req,
	vna_out_if.source rsp
);
	cmd_t cmd;
	sts_t sts;

	// sequencer: state, step counter, corner and component index
	vna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, shared multiplier, sqrt and divider, output register
	vna_dp #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (req.op),
		.vertex_index (req.vertex_index),
		.pos_x        (req.pos_x),
		.pos_y        (req.pos_y),
		.pos_z        (req.pos_z),
		.init_nx      (req.init_nx),
		.init_ny      (req.init_ny),
		.init_nz      (req.init_nz),
		.corner_a     (req.corner_a),
		.corner_b     (req.corner_b),
		.corner_c     (req.corner_c),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.status       (rsp.status),
		.out_nx       (rsp.out_nx),
		.out_ny       (rsp.out_ny),
		.out_nz       (rsp.out_nz)
	);
endmodule

[tb/vna_tb_if.sv]
`timescale 1ns / 1ps
// Shadow copy of the channel interfaces is not needed: the design's own
// interfaces (vna_in_if, vna_out_if) are instantiated directly by the bench.
// This file carries the bench-side word types shared by the test tasks.
package vna_tb_pkg;
	import vna_pkg::*;

	typedef struct {
		op_t                op;
		logic [15:0]        vertex_index;
		logic signed [31:0] pos [3];
		logic signed [31:0] init_n [3];
		logic [15:0]        corner [3];
	} req_word_t;

	typedef struct {
		logic               status;
		logic signed [31:0] n [3];
	} rsp_word_t;
endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import vna_pkg::*;
	import vna_tb_pkg::*;

	localparam int SLOTS = 1024;
	// drain margin after last result
	localparam int TAIL_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	vna_in_if  req();
	vna_out_if rsp();

	vertex_normal_accumulator #(.VERTEX_SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// bench copy of the vertex stores
	logic signed [31:0] pos_mirror [SLOTS][3];
	logic signed [31:0] nrm_mirror [SLOTS][3];
	bit                 loaded [SLOTS];

	rsp_word_t expected_q [$];
	int  fail_count = 0;
	bit  rx_idle_en = 1'b1;
	bit  tx_idle_en = 1'b1;
	int  rx_hold = 0;        // long receiver stall, in cycles
	int  rx_hold_req = 0;    // stall length requested by a test

	// ---------------- prediction ----------------
	function automatic logic [63:0] sqrt_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
			logic signed [63:0] b);
		logic signed [63:0] s;
		s = 64'(a) + b;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic logic [63:0] abs64(logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// unit face normal, Q16.16
	task automatic face_normal(input int ia, ib, ic, output logic signed [63:0] n [3]);
		logic signed [63:0] e1 [3], e2 [3], cr [3];
		logic [63:0] m [3], top, len;
		bit ng [3];
		bit wide;
		wide = 0;
		top = 0;
		for (int k = 0; k < 3; k++) begin
			e1[k] = 64'(pos_mirror[ib][k]) - 64'(pos_mirror[ia][k]);
			e2[k] = 64'(pos_mirror[ic][k]) - 64'(pos_mirror[ia][k]);
			if (abs64(e1[k]) >= 64'h8000_0000 || abs64(e2[k]) >= 64'h8000_0000)
				wide = 1;
		end
		if (wide) begin
			// halve magnitudes, keep sign
			for (int k = 0; k < 3; k++) begin
				e1[k] = e1[k] < 0 ? -64'(abs64(e1[k]) >> 1) : 64'(abs64(e1[k]) >> 1);
				e2[k] = e2[k] < 0 ? -64'(abs64(e2[k]) >> 1) : 64'(abs64(e2[k]) >> 1);
			end
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		for (int k = 0; k < 3; k++) begin
			ng[k] = cr[k] < 0;
			m[k] = abs64(cr[k]);
			if (m[k] > top) top = m[k];
			n[k] = 0;
		end
		if (top == 0) return;
		while (top >= 64'h8000_0000) begin
			top = top >> 1;
			for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
		end
		while (top < 64'h4000_0000) begin
			top = top << 1;
			for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
		end
		len = sqrt_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		if (len == 0) return;
		for (int k = 0; k < 3; k++)
			n[k] = ng[k] ? -64'((m[k] << 16) / len) : 64'((m[k] << 16) / len);
	endtask

	task automatic predict_word(input req_word_t w);
		rsp_word_t r;
		logic signed [63:0] fn [3];
		r.status = 0;
		for (int k = 0; k < 3; k++) r.n[k] = 0;
		case (w.op)
			OP_LOAD: begin
				if (w.vertex_index >= SLOTS) r.status = 1;
				else begin
					for (int k = 0; k < 3; k++) begin
						pos_mirror[w.vertex_index][k] = w.pos[k];
						nrm_mirror[w.vertex_index][k] = w.init_n[k];
					end
					loaded[w.vertex_index] = 1;
				end
			end
			OP_TRI: begin
				if (w.corner[0] >= SLOTS || w.corner[1] >= SLOTS || w.corner[2] >= SLOTS)
					r.status = 1;
				else begin
					face_normal(w.corner[0], w.corner[1], w.corner[2], fn);
					for (int j = 0; j < 3; j++)
						for (int k = 0; k < 3; k++)
							nrm_mirror[w.corner[j]][k] = sat_sum(nrm_mirror[w.corner[j]][k], fn[k]);
				end
			end
			OP_READ: begin
				if (w.vertex_index >= SLOTS) r.status = 1;
				else for (int k = 0; k < 3; k++) r.n[k] = nrm_mirror[w.vertex_index][k];
			end
			default: ;
		endcase
		expected_q.push_back(r);
	endtask

	// ---------------- driving ----------------
	initial begin
		req.valid = 0; req.op = '0; req.vertex_index = '0;
		req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
		req.init_nx = '0; req.init_ny = '0; req.init_nz = '0;
		req.corner_a = '0; req.corner_b = '0; req.corner_c = '0;
		rsp.ready = 0;
	end

	task automatic send_word(input req_word_t w);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1;
		req.op <= w.op;
		req.vertex_index <= w.vertex_index;
		req.pos_x <= w.pos[0]; req.pos_y <= w.pos[1]; req.pos_z <= w.pos[2];
		req.init_nx <= w.init_n[0]; req.init_ny <= w.init_n[1];
		req.init_nz <= w.init_n[2];
		req.corner_a <= w.corner[0]; req.corner_b <= w.corner[1];
		req.corner_c <= w.corner[2];
		do @(posedge clk); while (!req.ready);
		predict_word(w);
	endtask

	task automatic go_idle();
		req.valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		go_idle();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// ---------------- receiving / checking ----------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_hold_req > 0) begin
				rsp.ready <= 0;
				rx_hold <= rx_hold_req;
				rx_hold_req = 0;
			end else if (rx_hold > 0) begin
				rsp.ready <= 0;
				rx_hold <= rx_hold - 1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 0;
				rx_hold <= $urandom_range(0, 5);
			end else begin
				rsp.ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_word_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word status=%0b n=%0d %0d %0d", $time,
					rsp.status, rsp.out_nx, rsp.out_ny, rsp.out_nz);
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (rsp.status !== e.status || rsp.out_nx !== e.n[0] ||
						rsp.out_ny !== e.n[1] || rsp.out_nz !== e.n[2]) begin
					$display("%0t: mismatch exp status=%0b n=%0d %0d %0d", $time,
						e.status, e.n[0], e.n[1], e.n[2]);
					$display("%0t:          act status=%0b n=%0d %0d %0d", $time,
						rsp.status, rsp.out_nx, rsp.out_ny, rsp.out_nz);
					fail_count++;
				end
			end
		end
	end

	// ---------------- word builders ----------------
	function automatic req_word_t blank_word(op_t op);
		req_word_t w;
		w.op = op;
		w.vertex_index = 16'($urandom);
		for (int k = 0; k < 3; k++) begin
			w.pos[k] = $urandom;
			w.init_n[k] = $urandom;
			w.corner[k] = 16'($urandom);
		end
		return w;
	endfunction

	function automatic req_word_t load_word(int vi, logic signed [31:0] px, py, pz,
			logic signed [31:0] nx, ny, nz);
		req_word_t w;
		w = blank_word(OP_LOAD);
		w.vertex_index = 16'(vi);
		w.pos[0] = px; w.pos[1] = py; w.pos[2] = pz;
		w.init_n[0] = nx; w.init_n[1] = ny; w.init_n[2] = nz;
		return w;
	endfunction

	function automatic req_word_t tri_word(int a, b, c);
		req_word_t w;
		w = blank_word(OP_TRI);
		w.corner[0] = 16'(a); w.corner[1] = 16'(b); w.corner[2] = 16'(c);
		return w;
	endfunction

	function automatic req_word_t read_word(int vi);
		req_word_t w;
		w = blank_word(OP_READ);
		w.vertex_index = 16'(vi);
		return w;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;                            // full range, wide edges
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_norm();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_FFFF; // near limits
			default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		endcase
	endfunction

	function automatic int rand_loaded();
		int vi;
		do vi = $urandom_range(0, SLOTS - 1); while (!loaded[vi]);
		return vi;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		send_word(load_word(0, 0, 0, 0, 0, 0, 0));
		send_word(load_word(1, 1 << 16, 0, 0, 32'h7FFF_FFF0, 0, 32'h8000_0010));
		send_word(load_word(2, 0, 1 << 16, 0, 0, 0, 0));
		send_word(load_word(SLOTS - 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_word(load_word(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
		send_word(load_word(SLOTS, 0, 0, 0, 0, 0, 0));      // out of range
		send_word(load_word(16'hFFFF, 0, 0, 0, 0, 0, 0));
		send_word(tri_word(0, 1, 2));                       // +z unit normal
		send_word(tri_word(0, 1, 2));
		send_word(tri_word(0, 0, 1));                       // repeated corner
		send_word(tri_word(0, 1, 1));
		send_word(tri_word(3, SLOTS - 1, 0));               // wide edges, halving
		send_word(tri_word(1, 2, SLOTS));                   // out of range
		send_word(tri_word(16'hFFFF, 0, 1));
		send_word(tri_word(0, 16'hFFFF, 1));
		send_word(blank_word(OP_NONE));
		for (int v = 0; v < 4; v++) send_word(read_word(v));
		send_word(read_word(SLOTS - 1));
		send_word(read_word(SLOTS));
		send_word(read_word(16'hFFFF));
		wait_drained();
	endtask

	task automatic random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			send_word(load_word($urandom_range(0, SLOTS - 1), rand_coord(), rand_coord(),
				rand_coord(), rand_norm(), rand_norm(), rand_norm()));
		else if (pick < 30)
			send_word(load_word($urandom_range(SLOTS, 65535), rand_coord(), 0, 0, 0, 0, 0));
		else if (pick < 65)
			send_word(tri_word(rand_loaded(), rand_loaded(), rand_loaded()));
		else if (pick < 69)
			send_word(tri_word(rand_loaded(), $urandom_range(0, 1) ? rand_loaded() :
				$urandom_range(SLOTS, 65535), $urandom_range(SLOTS, 65535))); // bad corner
		else if (pick < 95)
			send_word(read_word(rand_loaded()));
		else if (pick < 98)
			send_word(read_word($urandom_range(SLOTS, 65535)));
		else
			send_word(blank_word(OP_NONE));
	endtask

	// random mix of ops; triangle corners are drawn from the loaded slots
	task automatic test_random_mesh(int count);
		for (int i = 0; i < count; i++) random_word();
	endtask

	task automatic test_backpressure();
		// receiver stalls long; sender keeps offering until input stalls
		rx_hold_req = 300;
		for (int i = 0; i < 20; i++) random_word();
		wait_drained();
		// sender pauses until everything has come back
		for (int i = 0; i < 10; i++) random_word();
		wait_drained();
	endtask

	task automatic test_no_idle(int count);
		tx_idle_en = 0;
		rx_idle_en = 0;
		test_random_mesh(count);
		wait_drained();
	endtask

	initial begin
		for (int v = 0; v < SLOTS; v++) loaded[v] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_mesh(900);
		wait_drained();
		test_backpressure();
		test_no_idle(350);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule

[vertex_normal_accumulator.f]
design/vna_pkg.sv
design/vna_if.sv
design/vna_ram.sv
design/vna_ctrl.sv
design/vna_dp.sv
design/vertex_normal_accumulator.sv
tb/vna_tb_if.sv
tb/testbench.sv
